### rtl/core/split_link_latency_sync_and_key_delay_unit_assert.svh
// Assertion macros shared by the split link latency unit.
`ifndef SPLIT_LINK_LATENCY_SYNC_AND_KEY_DELAY_UNIT_ASSERT_SVH
`define SPLIT_LINK_LATENCY_SYNC_AND_KEY_DELAY_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SLL_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// Implication checked in the cycle after the antecedent.
`define SLL_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

### rtl/core/sll_pkg.sv
// ----------------------------------------------------------------------------
// Split link latency package
// Shared types and constants of the split link latency unit.
// ----------------------------------------------------------------------------
package sll_pkg;
  localparam int Samples = 10;
  localparam int Keys = 32;
  localparam int PosW = $clog2(Samples);
  localparam logic [PosW-1:0] PosLast = PosW'(Samples - 1);
  localparam int SumW = 12;
  localparam int Divisor = 2 * (Samples - 2);
  localparam logic [15:0] IdleReset = 16'd5000;
  localparam logic [Keys-1:0] KeyMask = {Keys{1'b1}};

  typedef enum logic [3:0] {
    PH_NOT_CONN   = 4'd0,
    PH_FIRST_CONN = 4'd1,
    PH_START_FULL = 4'd2,
    PH_LEFT_SENT  = 4'd3,
    PH_LEFT_RECV  = 4'd4,
    PH_RIGHT_SENT = 4'd5,
    PH_RIGHT_RECV = 4'd6,
    PH_END_FULL   = 4'd7,
    PH_IDLE       = 4'd8,
    PH_PING       = 4'd9,
    PH_START_PING = 4'd10,
    PH_LR_SENT    = 4'd11,
    PH_LR_RECV    = 4'd12,
    PH_END_PING   = 4'd13,
    PH_RSV14      = 4'd14,
    PH_RSV15      = 4'd15
  } phase_t;

  typedef enum logic [2:0] {
    C_IDLE, C_SEQ, C_SCAN, C_DIV, C_KEYS, C_OUT
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic seq_step;
    logic scan_start;
    logic scan_step;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic is_resp;
    logic seq_again;
    logic seq_update;
    logic scan_last;
  } stat_t;
endpackage

### rtl/core/split_link_latency_sync_and_key_delay_unit.sv
// ----------------------------------------------------------------------------
// Split link latency sync and key delay unit
// Channel  | Handshake                 | Payload
// input    | in_valid / in_ready       | command, now_ms, link and key words
// output   | out_valid / out_ready     | reported keys, sync sends, delay
// config   | cfg_valid / cfg_ready     | cfg_data (idle_ping_ms)
// A response word goes from load straight to the result; a tick steps the sequencer first.
// A latency update adds a scan of the sample rings and a divide step.
// One word is in flight at a time; a stalled result holds the input off.
// Synchronous reset restores all but the input word and scan registers; no clearing pass.
// ----------------------------------------------------------------------------
module split_link_latency_sync_and_key_delay_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [31:0] now_ms,
  input  logic        both_connected,
  input  logic        report_left,
  input  logic [31:0] left_keys,
  input  logic [31:0] left_prev_keys,
  input  logic [31:0] right_keys,
  input  logic [31:0] right_prev_keys,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_left_keys,
  output logic [31:0] out_right_keys,
  output logic        send_sync_left,
  output logic        send_sync_right,
  output logic        left_faster,
  output logic [6:0]  delay_now
);
  sll_pkg::cmd_t cmd;
  sll_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  sll_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_valid && in_ready),
    .out_fire(out_valid && out_ready), .stat(stat), .cmd(cmd),
    .in_ready(in_ready), .out_valid(out_valid)
  );

  sll_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .command(command), .now_ms(now_ms), .both_connected(both_connected),
    .report_left(report_left), .left_keys(left_keys),
    .left_prev_keys(left_prev_keys), .right_keys(right_keys),
    .right_prev_keys(right_prev_keys), .out_left_keys(out_left_keys),
    .out_right_keys(out_right_keys), .send_sync_left(send_sync_left),
    .send_sync_right(send_sync_right), .left_faster(left_faster),
    .delay_now(delay_now)
  );
endmodule

### rtl/core/sll_ctrl.sv
// ----------------------------------------------------------------------------
// Split link latency controller
// Steps each word through the sequencer and, as needed, ring scan, divide and key handling.
// ----------------------------------------------------------------------------
module sll_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_fire,
  input  logic            out_fire,
  input  sll_pkg::stat_t  stat,
  output sll_pkg::cmd_t   cmd,
  output logic            in_ready,
  output logic            out_valid
);
  sll_pkg::ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sll_pkg::C_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      sll_pkg::C_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.load = 1'b1;
          state_next = sll_pkg::C_SEQ;
        end
      end
      sll_pkg::C_SEQ: begin
        if (stat.is_resp) begin
          state_next = sll_pkg::C_OUT;
          cmd.finish = 1'b1;
        end else begin
          cmd.seq_step = 1'b1;
          if (stat.seq_update) begin
            cmd.scan_start = 1'b1;
            state_next = sll_pkg::C_SCAN;
          end else if (!stat.seq_again) begin
            state_next = sll_pkg::C_KEYS;
          end
        end
      end
      sll_pkg::C_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_next = sll_pkg::C_DIV;
        end
      end
      sll_pkg::C_DIV: begin
        cmd.div_step = 1'b1;
        state_next = stat.seq_again ? sll_pkg::C_SEQ : sll_pkg::C_KEYS;
      end
      sll_pkg::C_KEYS: begin
        cmd.finish = 1'b1;
        state_next = sll_pkg::C_OUT;
      end
      sll_pkg::C_OUT: begin
        out_valid = 1'b1;
        if (out_fire) begin
          state_next = sll_pkg::C_IDLE;
        end
      end
      default: state_next = sll_pkg::C_IDLE;
    endcase
  end

  `include "split_link_latency_sync_and_key_delay_unit_assert.svh"
  `SLL_ASSERT_IMP(a_ready_idle, clk, rst, in_ready, state == sll_pkg::C_IDLE)
  `SLL_ASSERT_NEXT(a_load_seq, clk, rst, in_fire, state == sll_pkg::C_SEQ)
  `SLL_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_fire, out_valid)
endmodule

### rtl/core/sll_datapath.sv
// ----------------------------------------------------------------------------
// Split link latency datapath
// Holds the sequencer state, sample rings, latencies and change buffer.
// ----------------------------------------------------------------------------
module sll_datapath (
  input  logic                clk,
  input  logic                rst,
  input  sll_pkg::cmd_t       cmd,
  output sll_pkg::stat_t      stat,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [15:0]         cfg_data,
  input  logic                command,
  input  logic [31:0]         now_ms,
  input  logic                both_connected,
  input  logic                report_left,
  input  logic [31:0]         left_keys,
  input  logic [31:0]         left_prev_keys,
  input  logic [31:0]         right_keys,
  input  logic [31:0]         right_prev_keys,
  output logic [31:0]         out_left_keys,
  output logic [31:0]         out_right_keys,
  output logic                send_sync_left,
  output logic                send_sync_right,
  output logic                left_faster,
  output logic [6:0]          delay_now
);
  logic [15:0] idle_ping_ms;
  sll_pkg::phase_t sync_phase, phase_n;
  logic [31:0] send_stamp, last_activity, pending_stamp, pending_keys;
  logic ping_left, left_answered, right_answered, change_pending;
  logic [sll_pkg::PosW-1:0] left_ring_pos, right_ring_pos;
  logic [sll_pkg::PosW-1:0] left_pos_next, right_pos_next;
  logic [7:0] left_samples [sll_pkg::Samples];
  logic [7:0] right_samples [sll_pkg::Samples];
  logic [6:0] left_latency, right_latency, hold_delay;
  logic is_resp, conn;
  logic [31:0] now, lk, lp, rk, rp;
  logic again, upd;
  logic [sll_pkg::PosW-1:0] scan_idx;
  logic [7:0] lmin, lmax, rmin, rmax;
  logic [sll_pkg::SumW-1:0] lsum, rsum, ltrim, rtrim;
  logic [6:0] lq, rq;
  logic [31:0] delta;
  logic [7:0] sat;
  logic lf;
  logic [31:0] hb_in, hb_prev, hb_out;
  logic hb_expired;

  assign delta = now_ms - send_stamp;
  assign sat = (delta > 32'd255) ? 8'hFF : delta[7:0];
  assign left_pos_next = (left_ring_pos == sll_pkg::PosLast) ? '0 : left_ring_pos + 1'b1;
  assign right_pos_next = (right_ring_pos == sll_pkg::PosLast) ? '0 : right_ring_pos + 1'b1;

  assign ltrim = lsum - sll_pkg::SumW'(lmin) - sll_pkg::SumW'(lmax);
  assign rtrim = rsum - sll_pkg::SumW'(rmin) - sll_pkg::SumW'(rmax);
  assign lq = 7'(ltrim / sll_pkg::SumW'(sll_pkg::Divisor));
  assign rq = 7'(rtrim / sll_pkg::SumW'(sll_pkg::Divisor));

  assign lf = left_latency < right_latency;
  assign hb_in = lf ? lk : rk;
  assign hb_prev = lf ? lp : rp;
  assign hb_expired = (now - pending_stamp) > {25'd0, hold_delay};

  always_comb begin
    hb_out = hb_in;
    if (hb_in != hb_prev) begin
      if (change_pending) begin
        if (pending_keys != hb_in) hb_out = pending_keys;
        else if (!hb_expired) hb_out = hb_prev;
      end else begin
        hb_out = hb_prev;
      end
    end else if (change_pending && hb_expired) begin
      hb_out = pending_keys;
    end
  end

  always_comb begin
    phase_n = sync_phase;
    again = 1'b0;
    upd = 1'b0;
    unique case (sync_phase)
      sll_pkg::PH_NOT_CONN: if (conn) begin
        phase_n = sll_pkg::PH_FIRST_CONN; again = 1'b1;
      end
      sll_pkg::PH_FIRST_CONN: begin phase_n = sll_pkg::PH_START_FULL; again = 1'b1; end
      sll_pkg::PH_START_FULL: phase_n = sll_pkg::PH_LEFT_SENT;
      sll_pkg::PH_LEFT_SENT: if (left_answered) begin
        phase_n = sll_pkg::PH_LEFT_RECV; again = 1'b1;
      end
      sll_pkg::PH_LEFT_RECV: phase_n = sll_pkg::PH_RIGHT_SENT;
      sll_pkg::PH_RIGHT_SENT: if (right_answered) begin
        phase_n = sll_pkg::PH_RIGHT_RECV; again = 1'b1;
      end
      sll_pkg::PH_RIGHT_RECV: begin phase_n = sll_pkg::PH_END_FULL; again = 1'b1; end
      sll_pkg::PH_END_FULL: begin
        again = 1'b1;
        if (left_ring_pos == '0 && right_ring_pos == '0) begin
          phase_n = sll_pkg::PH_IDLE; upd = 1'b1;
        end else begin
          phase_n = sll_pkg::PH_START_FULL;
        end
      end
      sll_pkg::PH_IDLE: if (last_activity != '0 &&
                            (now - last_activity) > {16'd0, idle_ping_ms}) begin
        phase_n = sll_pkg::PH_PING; again = 1'b1;
      end
      sll_pkg::PH_PING: begin phase_n = sll_pkg::PH_START_PING; again = 1'b1; end
      sll_pkg::PH_START_PING: phase_n = sll_pkg::PH_LR_SENT;
      sll_pkg::PH_LR_SENT: if (ping_left ? left_answered : right_answered) begin
        phase_n = sll_pkg::PH_LR_RECV; again = 1'b1;
      end
      sll_pkg::PH_LR_RECV: begin phase_n = sll_pkg::PH_END_PING; again = 1'b1; end
      sll_pkg::PH_END_PING: begin phase_n = sll_pkg::PH_IDLE; upd = 1'b1; end
      default: phase_n = sync_phase;
    endcase
  end

  assign stat.is_resp = is_resp;
  assign stat.seq_again = again;
  assign stat.seq_update = upd;
  assign stat.scan_last = (scan_idx == sll_pkg::PosLast);

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_ping_ms <= sll_pkg::IdleReset;
      sync_phase <= sll_pkg::PH_NOT_CONN;
      send_stamp <= '0; ping_left <= 1'b0;
      left_answered <= 1'b0; right_answered <= 1'b0;
      left_ring_pos <= '0; right_ring_pos <= '0;
      for (int i = 0; i < sll_pkg::Samples; i++) begin
        left_samples[i] <= '0; right_samples[i] <= '0;
      end
      left_latency <= '0; right_latency <= '0; hold_delay <= '0;
      last_activity <= '0; change_pending <= 1'b0;
      pending_stamp <= '0; pending_keys <= '0;
      scan_idx <= '0;
      out_left_keys <= '0; out_right_keys <= '0;
      send_sync_left <= 1'b0; send_sync_right <= 1'b0;
      left_faster <= 1'b0; delay_now <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        idle_ping_ms <= cfg_data;
      end
      if (cmd.load) begin
        is_resp <= command; now <= now_ms; conn <= both_connected;
        lk <= left_keys & sll_pkg::KeyMask; lp <= left_prev_keys & sll_pkg::KeyMask;
        rk <= right_keys & sll_pkg::KeyMask; rp <= right_prev_keys & sll_pkg::KeyMask;
        send_sync_left <= 1'b0; send_sync_right <= 1'b0;
        if (command) begin
          if (report_left) begin
            left_ring_pos <= left_pos_next;
            left_samples[left_pos_next] <= sat;
            left_answered <= 1'b1;
          end else begin
            right_ring_pos <= right_pos_next;
            right_samples[right_pos_next] <= sat;
            right_answered <= 1'b1;
          end
        end
      end
      if (cmd.seq_step) begin
        sync_phase <= phase_n;
        unique case (sync_phase)
          sll_pkg::PH_START_FULL: begin
            send_sync_left <= 1'b1; send_stamp <= now; ping_left <= 1'b1;
            left_answered <= 1'b0;
          end
          sll_pkg::PH_LEFT_RECV: begin
            send_sync_right <= 1'b1; send_stamp <= now; ping_left <= 1'b0;
            right_answered <= 1'b0;
          end
          sll_pkg::PH_IDLE: if (phase_n == sll_pkg::PH_PING) last_activity <= '0;
          sll_pkg::PH_PING: ping_left <= !ping_left;
          sll_pkg::PH_START_PING: begin
            if (ping_left) send_sync_left <= 1'b1; else send_sync_right <= 1'b1;
            send_stamp <= now;
          end
          sll_pkg::PH_END_PING: last_activity <= '0;
          default: ;
        endcase
      end
      if (cmd.scan_start) begin
        scan_idx <= '0;
        lmin <= 8'hFF; lmax <= '0; lsum <= '0;
        rmin <= 8'hFF; rmax <= '0; rsum <= '0;
      end
      if (cmd.scan_step) begin
        scan_idx <= scan_idx + 1'b1;
        if (left_samples[scan_idx] < lmin) lmin <= left_samples[scan_idx];
        if (left_samples[scan_idx] > lmax) lmax <= left_samples[scan_idx];
        lsum <= lsum + sll_pkg::SumW'(left_samples[scan_idx]);
        if (right_samples[scan_idx] < rmin) rmin <= right_samples[scan_idx];
        if (right_samples[scan_idx] > rmax) rmax <= right_samples[scan_idx];
        rsum <= rsum + sll_pkg::SumW'(right_samples[scan_idx]);
      end
      if (cmd.div_step) begin
        left_latency <= lq;
        right_latency <= rq;
        hold_delay <= (lq > rq) ? lq - rq : rq - lq;
      end
      if (cmd.finish) begin
        left_faster <= lf;
        delay_now <= hold_delay;
        if (is_resp) begin
          out_left_keys <= '0; out_right_keys <= '0;
          send_sync_left <= 1'b0; send_sync_right <= 1'b0;
        end else begin
          if (lk != '0 || rk != '0) last_activity <= now;
          out_left_keys <= lf ? hb_out : lk;
          out_right_keys <= lf ? rk : hb_out;
          if (hb_in != hb_prev) begin
            if (change_pending) begin
              if (pending_keys != hb_in) begin
                pending_keys <= hb_in; pending_stamp <= now;
              end else if (hb_expired) begin
                change_pending <= 1'b0;
              end
            end else begin
              change_pending <= 1'b1; pending_stamp <= now; pending_keys <= hb_in;
            end
          end else if (change_pending && hb_expired) begin
            pending_keys <= hb_in; change_pending <= 1'b0;
          end
        end
      end
    end
  end

  `include "split_link_latency_sync_and_key_delay_unit_assert.svh"
  `SLL_ASSERT_IMP(a_left_pos, clk, rst, 1'b1, left_ring_pos <= sll_pkg::PosLast)
  `SLL_ASSERT_IMP(a_right_pos, clk, rst, 1'b1, right_ring_pos <= sll_pkg::PosLast)
  `SLL_ASSERT_IMP(a_one_send, clk, rst, 1'b1, !(send_sync_left && send_sync_right))
endmodule

### sim/split_link_latency_sync_and_key_delay_unit_checker.sv
// ----------------------------------------------------------------------------
// Split link latency checker
// Watches the input, output and register channels of the unit, keeps its own
// copy of the sync sequencer, the sample rings and the hold-back buffer, and
// compares every result word with the oldest expected word.
// ----------------------------------------------------------------------------
module split_link_latency_sync_and_key_delay_unit_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        command,
  input  logic [31:0] now_ms,
  input  logic        both_connected,
  input  logic        report_left,
  input  logic [31:0] left_keys,
  input  logic [31:0] left_prev_keys,
  input  logic [31:0] right_keys,
  input  logic [31:0] right_prev_keys,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_left_keys,
  input  logic [31:0] out_right_keys,
  input  logic        send_sync_left,
  input  logic        send_sync_right,
  input  logic        left_faster,
  input  logic [6:0]  delay_now,
  output int          fail_count,
  output int          pending_count,
  output int          sync_count,
  output int          update_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] lk;
    logic [31:0] rk;
    logic        sl;
    logic        sr;
    logic        lf;
    logic [6:0]  dly;
  } report_t;

  report_t          expected_reports[$];
  logic [15:0]      idle_ms;
  sll_pkg::phase_t  phase;
  logic [31:0]      stamp;
  logic             ping_l, ans_l, ans_r;
  int               pos_l, pos_r;
  logic [7:0]       ring_l[sll_pkg::Samples];
  logic [7:0]       ring_r[sll_pkg::Samples];
  logic [6:0]       lat_l, lat_r, hold;
  logic [31:0]      activity;
  logic             buf_full;
  logic [31:0]      buf_stamp, buf_keys;

  function automatic logic [6:0] trimmed(input logic [7:0] ring[sll_pkg::Samples]);
    int mn, mx, sum;
    mn = 255;
    mx = 0;
    sum = 0;
    for (int i = 0; i < sll_pkg::Samples; i++) begin
      if (ring[i] < mn) mn = ring[i];
      if (ring[i] > mx) mx = ring[i];
      sum += ring[i];
    end
    return 7'((sum - mn - mx) / sll_pkg::Divisor);
  endfunction

  task automatic refresh_latency();
    lat_l = trimmed(ring_l);
    lat_r = trimmed(ring_r);
    hold = (lat_l > lat_r) ? lat_l - lat_r : lat_r - lat_l;
    update_count++;
  endtask

  task automatic hold_back(input logic [31:0] now, inout logic [31:0] down,
                           input logic [31:0] prev);
    logic [31:0] res;
    res = down;
    if (down != prev) begin
      if (buf_full) begin
        if (buf_keys != down) begin
          res = buf_keys;
          buf_keys = down;
          buf_stamp = now;
        end else if (now - buf_stamp > 32'(hold)) begin
          buf_full = 1'b0;
        end else begin
          res = prev;
        end
      end else begin
        buf_full = 1'b1;
        buf_stamp = now;
        buf_keys = down;
        res = prev;
      end
    end else if (buf_full && now - buf_stamp > 32'(hold)) begin
      res = buf_keys;
      buf_keys = down;
      buf_full = 1'b0;
    end
    down = res;
  endtask

  task automatic predict_word();
    report_t     r;
    logic [31:0] d, lk, rk;
    logic        again;
    r = '0;
    if (command) begin
      d = now_ms - stamp;
      if (d > 32'd255) d = 32'd255;
      if (report_left) begin
        pos_l = (pos_l + 1) % sll_pkg::Samples;
        ring_l[pos_l] = d[7:0];
        ans_l = 1'b1;
      end else begin
        pos_r = (pos_r + 1) % sll_pkg::Samples;
        ring_r[pos_r] = d[7:0];
        ans_r = 1'b1;
      end
      r.lf = lat_l < lat_r;
      r.dly = hold;
      expected_reports.push_back(r);
      return;
    end
    lk = left_keys & sll_pkg::KeyMask;
    rk = right_keys & sll_pkg::KeyMask;
    do begin
      again = 1'b0;
      case (phase)
        sll_pkg::PH_NOT_CONN: begin
          if (both_connected) begin
            phase = sll_pkg::PH_FIRST_CONN;
            again = 1'b1;
          end
        end
        sll_pkg::PH_FIRST_CONN: begin
          phase = sll_pkg::PH_START_FULL;
          again = 1'b1;
        end
        sll_pkg::PH_START_FULL: begin
          r.sl = 1'b1;
          stamp = now_ms;
          phase = sll_pkg::PH_LEFT_SENT;
          ping_l = 1'b1;
          ans_l = 1'b0;
        end
        sll_pkg::PH_LEFT_SENT: begin
          if (ans_l) begin
            phase = sll_pkg::PH_LEFT_RECV;
            again = 1'b1;
          end
        end
        sll_pkg::PH_LEFT_RECV: begin
          r.sr = 1'b1;
          stamp = now_ms;
          phase = sll_pkg::PH_RIGHT_SENT;
          ping_l = 1'b0;
          ans_r = 1'b0;
        end
        sll_pkg::PH_RIGHT_SENT: begin
          if (ans_r) begin
            phase = sll_pkg::PH_RIGHT_RECV;
            again = 1'b1;
          end
        end
        sll_pkg::PH_RIGHT_RECV: begin
          phase = sll_pkg::PH_END_FULL;
          again = 1'b1;
        end
        sll_pkg::PH_END_FULL: begin
          if (pos_l == 0 && pos_r == 0) begin
            refresh_latency();
            phase = sll_pkg::PH_IDLE;
          end else begin
            phase = sll_pkg::PH_START_FULL;
          end
          again = 1'b1;
        end
        sll_pkg::PH_IDLE: begin
          if (activity != 0 && now_ms - activity > 32'(idle_ms)) begin
            activity = '0;
            phase = sll_pkg::PH_PING;
            again = 1'b1;
          end
        end
        sll_pkg::PH_PING: begin
          phase = sll_pkg::PH_START_PING;
          ping_l = !ping_l;
          again = 1'b1;
        end
        sll_pkg::PH_START_PING: begin
          if (ping_l) r.sl = 1'b1;
          else r.sr = 1'b1;
          stamp = now_ms;
          phase = sll_pkg::PH_LR_SENT;
        end
        sll_pkg::PH_LR_SENT: begin
          if (ping_l ? ans_l : ans_r) begin
            phase = sll_pkg::PH_LR_RECV;
            again = 1'b1;
          end
        end
        sll_pkg::PH_LR_RECV: begin
          phase = sll_pkg::PH_END_PING;
          again = 1'b1;
        end
        sll_pkg::PH_END_PING: begin
          phase = sll_pkg::PH_IDLE;
          refresh_latency();
          activity = '0;
        end
        default: begin
        end
      endcase
    end while (again);
    if (r.sl || r.sr) sync_count++;
    if (lk != 0 || rk != 0) activity = now_ms;
    r.lf = lat_l < lat_r;
    if (r.lf) hold_back(now_ms, lk, left_prev_keys & sll_pkg::KeyMask);
    else hold_back(now_ms, rk, right_prev_keys & sll_pkg::KeyMask);
    r.lk = lk;
    r.rk = rk;
    r.dly = hold;
    expected_reports.push_back(r);
  endtask

  always @(posedge clk) begin
    report_t e, a;
    if (rst) begin
      expected_reports.delete();
      idle_ms <= sll_pkg::IdleReset;
      phase = sll_pkg::PH_NOT_CONN;
      stamp = '0;
      ping_l = 1'b0;
      ans_l = 1'b0;
      ans_r = 1'b0;
      pos_l = 0;
      pos_r = 0;
      for (int i = 0; i < sll_pkg::Samples; i++) begin
        ring_l[i] = '0;
        ring_r[i] = '0;
      end
      lat_l = '0;
      lat_r = '0;
      hold = '0;
      activity = '0;
      buf_full = 1'b0;
      buf_stamp = '0;
      buf_keys = '0;
      fail_count <= 0;
      sync_count = 0;
      update_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) idle_ms <= cfg_data;
      if (out_valid && out_ready) begin
        a = '{out_left_keys, out_right_keys, send_sync_left, send_sync_right,
              left_faster, delay_now};
        if (expected_reports.size() == 0) begin
          if (fail_count < 10) $display("unexpected result word %h", a);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_reports.pop_front();
          if (a !== e) begin
            if (fail_count < 10)
              $display("mismatch: expected lk=%h rk=%h sl=%b sr=%b lf=%b d=%0d, %s",
                e.lk, e.rk, e.sl, e.sr, e.lf, e.dly,
                $sformatf("got lk=%h rk=%h sl=%b sr=%b lf=%b d=%0d",
                  a.lk, a.rk, a.sl, a.sr, a.lf, a.dly));
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) predict_word();
    end
    pending_count = expected_reports.size();
  end
endmodule

### sim/split_link_latency_sync_and_key_delay_unit_tb.sv
// ----------------------------------------------------------------------------
// Split link latency unit testbench
// Drives tick and sync response words through the unit under several idling
// phases and register settings; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module split_link_latency_sync_and_key_delay_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LimitCycles = 1000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0, cfg_ready;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0, in_ready;
  logic        command = 1'b0;
  logic [31:0] now_ms = '0;
  logic        both_connected = 1'b0, report_left = 1'b0;
  logic [31:0] left_keys = '0, left_prev_keys = '0;
  logic [31:0] right_keys = '0, right_prev_keys = '0;
  logic        out_valid, out_ready = 1'b0;
  logic [31:0] out_left_keys, out_right_keys;
  logic        send_sync_left, send_sync_right, left_faster;
  logic [6:0]  delay_now;
  int          fail_count, pending_count, sync_count, update_count;
  int          cycles = 0;
  int          send_idle = 0, recv_stall = 0;
  int          hold_off = 0;
  logic        hold_start = 1'b0;
  int          words = 0;
  logic [31:0] clock_ms = '0;
  logic [31:0] last_l = '0, last_r = '0;

  always #5 clk = ~clk;

  split_link_latency_sync_and_key_delay_unit dut (.*);
  split_link_latency_sync_and_key_delay_unit_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LimitCycles) begin
      $display("timeout after %0d cycles", cycles);
      $display("** split_link_latency_sync_and_key_delay_unit: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_start) begin
      hold_off <= 400;
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  function automatic logic [31:0] key_word(input logic [31:0] last);
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return last;
      3: return last ^ (32'd1 << $urandom_range(31));
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input logic cmd, input logic [31:0] t, input logic conn,
                           input logic rl, input logic [31:0] lk, input logic [31:0] lp,
                           input logic [31:0] rk, input logic [31:0] rp);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    now_ms <= t;
    both_connected <= conn;
    report_left <= rl;
    left_keys <= lk;
    left_prev_keys <= lp;
    right_keys <= rk;
    right_prev_keys <= rp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words++;
  endtask

  task automatic tick(input logic [31:0] lk, input logic [31:0] rk);
    clock_ms += $urandom_range(3) == 0 ? $urandom_range(9000) : $urandom_range(40);
    send_word(1'b0, clock_ms, $urandom_range(7) != 0, 1'($urandom), lk, last_l, rk, last_r);
    last_l = lk;
    last_r = rk;
  endtask

  task automatic answer(input logic rl);
    clock_ms += $urandom_range(3) == 0 ? $urandom_range(400) : $urandom_range(60);
    send_word(1'b1, clock_ms, 1'($urandom), rl, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_idle(input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input int n, input int si, input int rs);
    send_idle = si;
    recv_stall = rs;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 6) begin
        tick(key_word(last_l), key_word(last_r));
      end else begin
        answer(1'($urandom));
      end
    end
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_word(1'b0, 32'd0, 1'b0, 1'b0, '1, '0, '0, '0);
    send_word(1'b1, 32'hFFFF_FFFF, 1'b0, 1'b1, '0, '0, '0, '0);
    send_word(1'b1, 32'd3, 1'b0, 1'b0, '0, '0, '0, '0);
    send_word(1'b0, 32'd0, 1'b1, 1'b0, '1, '0, '0, '0);
    for (int i = 0; i < 10; i++) begin
      answer(1'b1);
      tick('0, $urandom);
      answer(1'b0);
      tick($urandom, '0);
    end
    drain();
    write_idle(16'd1);
    random_phase(450, 0, 0);
    write_idle(16'hFFFF);
    random_phase(300, 70, 0);
    write_idle(16'd30);
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    random_phase(300, 0, 70);
    write_idle(sll_pkg::IdleReset);
    random_phase(300, 38, 38);
    write_idle(16'd200);
    random_phase(250, 0, 0);
    $display("%0d words sent, %0d sync requests, %0d latency updates seen",
             words, sync_count, update_count);
    if (fail_count == 0) begin
      $display("** split_link_latency_sync_and_key_delay_unit: PASSED **");
    end else begin
      $display("** split_link_latency_sync_and_key_delay_unit: FAILED **");
    end
    $finish;
  end
endmodule
